// ----- hdl/i2cmts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmts_pkg: shared types and codes of the I2C transaction sequencer
// Holds the command, result and operation codes and the word layouts of the
// input and result channels.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_EVENT = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // bus engine commands
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_ADDR      = 3'd1;
    localparam logic [2:0] CMD_DATA      = 3'd2;
    localparam logic [2:0] CMD_STOP      = 3'd3;
    localparam logic [2:0] CMD_ACK_RECV  = 3'd4;
    localparam logic [2:0] CMD_NACK_STOP = 3'd5;

    // transaction result codes
    localparam logic [2:0] RES_UNKNOWN   = 3'd0;
    localparam logic [2:0] RES_OK        = 3'd1;
    localparam logic [2:0] RES_FAIL      = 3'd2;
    localparam logic [2:0] RES_ARB_LOST  = 3'd3;
    localparam logic [2:0] RES_BUS_ERROR = 3'd4;
    localparam logic [2:0] RES_NACK      = 3'd5;

    // address byte direction bit
    localparam logic READ_BIT = 1'b1;

    // configuration register indexes and reset values
    localparam logic REG_IDLE_TIMEOUT = 1'b0;
    localparam logic [7:0] TIMEOUT_RESET = 8'd5;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [6:0] slave_address;
        logic [7:0] write_count;
        logic [7:0] read_count;
        logic [7:0] next_write_byte;
        logic       bus_error;
        logic       arbitration_lost;
        logic       write_done_flag;
        logic       read_done_flag;
        logic       slave_nacked;
        logic [7:0] received_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] bus_byte;
        logic       read_valid;
        logic [7:0] read_data;
        logic       clear_error_flags;
        logic       busy_res;
        logic [2:0] result_code;
        logic       restarted;
    } t_out_word;

endpackage
`default_nettype wire

// ----- hdl/i2c_master_transaction_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer: I2C write-then-read command sequencer
// Turns start requests, bus engine events and one-second ticks into the next
// bus engine command, tracking the transaction state and an idle watchdog.
// ----------------------------------------------------------------------------
// Pipeline: one input register, one result register, all decisions made
//   combinationally between them.
// Throughput: one word per cycle while results are taken; the input side
//   keeps taking words while a finished result waits, up to one word held in
//   the input register.
// Reset (synchronous, active low): no transaction busy, result unknown,
//   counters and address zero, idle timeout 5 seconds, both stages empty.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // input channel
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  i2cmts_pkg::t_in_word   i_in_word,
    // result channel
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output i2cmts_pkg::t_out_word  o_out_word,
    // configuration port
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [2:0]             paddr,
    input  wire  [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [7:0] r_idle_timeout;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == i2cmts_pkg::REG_IDLE_TIMEOUT);

    always_comb begin
        prdata = '0;
        if (paddr[2] == i2cmts_pkg::REG_IDLE_TIMEOUT) begin
            prdata[7:0] = r_idle_timeout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= i2cmts_pkg::TIMEOUT_RESET;
        end else if (cfg_write) begin
            r_idle_timeout <= pwdata[7:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register feeds the result register
    // ------------------------------------------------------------------
    logic                  r_in_valid;
    i2cmts_pkg::t_in_word  r_in;
    logic                  r_out_valid;
    i2cmts_pkg::t_out_word r_out;
    i2cmts_pkg::t_out_word n_out;
    logic                  out_free;
    logic                  s1_move;

    // result register frees up when empty or being taken this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // capture payloads; no reset needed
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // Transaction state
    // ------------------------------------------------------------------
    logic       r_busy;
    logic [2:0] r_last_result;
    logic [6:0] r_target_address;
    logic [7:0] r_writes_left;
    logic [7:0] r_reads_wanted;
    logic [7:0] r_reads_done;
    logic [7:0] r_idle_seconds;

    logic       n_busy;
    logic [2:0] n_last_result;
    logic [6:0] n_target_address;
    logic [7:0] n_writes_left;
    logic [7:0] n_reads_wanted;
    logic [7:0] n_reads_done;
    logic [7:0] n_idle_seconds;

    logic [7:0] reads_done_inc;
    logic [7:0] idle_inc;

    // saturating counters: hold at the top value
    assign reads_done_inc = (r_reads_done == i2cmts_pkg::COUNT_MAX) ?
                            r_reads_done : r_reads_done + 8'd1;
    assign idle_inc       = (r_idle_seconds == i2cmts_pkg::COUNT_MAX) ?
                            r_idle_seconds : r_idle_seconds + 8'd1;

    always_comb begin
        n_busy           = r_busy;
        n_last_result    = r_last_result;
        n_target_address = r_target_address;
        n_writes_left    = r_writes_left;
        n_reads_wanted   = r_reads_wanted;
        n_reads_done     = r_reads_done;
        n_idle_seconds   = r_idle_seconds;

        n_out                   = '0;
        n_out.bus_command       = i2cmts_pkg::CMD_NONE;

        unique case (r_in.operation)
            i2cmts_pkg::OP_START: begin
                // load a new transaction; replaces any one in flight
                n_busy           = 1'b1;
                n_last_result    = i2cmts_pkg::RES_UNKNOWN;
                n_target_address = r_in.slave_address;
                n_writes_left    = r_in.write_count;
                n_reads_wanted   = r_in.read_count;
                n_reads_done     = '0;
                if (r_in.write_count != '0) begin
                    n_out.bus_command = i2cmts_pkg::CMD_ADDR;
                    n_out.bus_byte    = {r_in.slave_address, ~i2cmts_pkg::READ_BIT};
                end else if (r_in.read_count != '0) begin
                    n_out.bus_command = i2cmts_pkg::CMD_ADDR;
                    n_out.bus_byte    = {r_in.slave_address, i2cmts_pkg::READ_BIT};
                end
            end
            i2cmts_pkg::OP_EVENT: begin
                // bus error outranks arbitration loss, then write, then read
                priority if (r_in.bus_error || r_in.arbitration_lost) begin
                    n_last_result = r_in.bus_error ? i2cmts_pkg::RES_BUS_ERROR :
                                                     i2cmts_pkg::RES_ARB_LOST;
                    n_out.clear_error_flags = 1'b1;
                    n_busy = 1'b0;
                end else if (r_in.write_done_flag) begin
                    n_idle_seconds = '0;
                    priority if (r_in.slave_nacked) begin
                        n_out.bus_command = i2cmts_pkg::CMD_STOP;
                        n_last_result     = i2cmts_pkg::RES_NACK;
                        n_busy            = 1'b0;
                    end else if (r_writes_left != '0) begin
                        n_writes_left     = r_writes_left - 8'd1;
                        n_out.bus_command = i2cmts_pkg::CMD_DATA;
                        n_out.bus_byte    = r_in.next_write_byte;
                    end else if (r_reads_done < r_reads_wanted) begin
                        // repeated start toward the read phase
                        n_out.bus_command = i2cmts_pkg::CMD_ADDR;
                        n_out.bus_byte    = {r_target_address, i2cmts_pkg::READ_BIT};
                    end else begin
                        n_out.bus_command = i2cmts_pkg::CMD_STOP;
                        n_last_result     = i2cmts_pkg::RES_OK;
                        n_busy            = 1'b0;
                    end
                end else if (r_in.read_done_flag) begin
                    n_out.read_valid = 1'b1;
                    n_out.read_data  = r_in.received_byte;
                    n_reads_done     = reads_done_inc;
                    if (reads_done_inc < r_reads_wanted) begin
                        n_out.bus_command = i2cmts_pkg::CMD_ACK_RECV;
                    end else begin
                        n_out.bus_command = i2cmts_pkg::CMD_NACK_STOP;
                        n_last_result     = i2cmts_pkg::RES_OK;
                        n_busy            = 1'b0;
                    end
                end else begin
                    // event with no flag: drop the transaction
                    n_last_result = i2cmts_pkg::RES_FAIL;
                    n_busy        = 1'b0;
                end
            end
            i2cmts_pkg::OP_TICK: begin
                // idle watchdog: fire once the count passes the timeout
                n_idle_seconds = idle_inc;
                if (idle_inc > r_idle_timeout) begin
                    n_idle_seconds  = '0;
                    n_last_result   = i2cmts_pkg::RES_UNKNOWN;
                    n_busy          = 1'b0;
                    n_out.restarted = 1'b1;
                end
            end
            default: begin
                // unused operation code: no state change
            end
        endcase

        n_out.busy_res    = n_busy;
        n_out.result_code = n_last_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy           <= 1'b0;
            r_last_result    <= i2cmts_pkg::RES_UNKNOWN;
            r_target_address <= '0;
            r_writes_left    <= '0;
            r_reads_wanted   <= '0;
            r_reads_done     <= '0;
            r_idle_seconds   <= '0;
        end else if (s1_move) begin
            r_busy           <= n_busy;
            r_last_result    <= n_last_result;
            r_target_address <= n_target_address;
            r_writes_left    <= n_writes_left;
            r_reads_wanted   <= n_reads_wanted;
            r_reads_done     <= n_reads_done;
            r_idle_seconds   <= n_idle_seconds;
        end
    end

`ifndef SYNTHESIS
    // a watchdog restart always leaves the block idle with an unknown result
    a_restart_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.restarted) |->
            (!r_out.busy_res && r_out.result_code == i2cmts_pkg::RES_UNKNOWN))
        else $error("watchdog restart left busy or a result set");

    // the idle counter is cleared right after a restart
    a_restart_clears_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && n_out.restarted) |=> (r_idle_seconds == '0))
        else $error("idle counter not cleared on restart");

    // a delivered read byte always comes with a receive or nack-stop command
    a_read_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.read_valid) |->
            (r_out.bus_command == i2cmts_pkg::CMD_ACK_RECV ||
             r_out.bus_command == i2cmts_pkg::CMD_NACK_STOP))
        else $error("read byte without matching command");

    // clearing the error flags ends the transaction with an error result
    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.clear_error_flags) |->
            (!r_out.busy_res &&
             (r_out.result_code == i2cmts_pkg::RES_BUS_ERROR ||
              r_out.result_code == i2cmts_pkg::RES_ARB_LOST)))
        else $error("error flag clear without error result");
`endif

endmodule
`default_nettype wire

// ----- tb/i2cmts_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmts_checker: result checker for the I2C transaction sequencer
// Watches the input, result and configuration ports, predicts each result
// word from its own copy of the sequencer state and compares it field by
// field.
// ----------------------------------------------------------------------------
module i2cmts_checker
    import i2cmts_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    input  wire          i_in_ready,
    input  t_in_word     i_in_word,
    input  wire          i_out_valid,
    input  wire          i_out_ready,
    input  t_out_word    i_out_word,
    input  wire          i_psel,
    input  wire          i_penable,
    input  wire          i_pwrite,
    input  wire  [2:0]   i_paddr,
    input  wire  [31:0]  i_pwdata,
    input  wire  [31:0]  i_prdata,
    input  wire          i_pready,
    output int           o_pending,
    output int           o_fail_count
);

    // shadow of the sequencer state and its register
    logic       busy;
    logic [2:0] last_res;
    logic [6:0] target;
    logic [7:0] writes_left;
    logic [7:0] reads_wanted;
    logic [7:0] reads_done;
    logic [7:0] idle_secs;
    logic [7:0] timeout_secs;

    t_out_word  awaited_results[$];
    int         mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t ns: %s mismatch, expected %0h got %0h", $time, what, want, got);
    endtask

    task automatic compare_field(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
            report_mismatch(what, 32'(want), 32'(got));
    endtask

    // advance the shadow state by one word and return the bus result it causes
    function automatic t_out_word next_bus_result(input t_in_word w);
        t_out_word r;
        r = '0;
        case (w.operation)
            OP_START: begin
                busy         = 1'b1;
                last_res     = RES_UNKNOWN;
                target       = w.slave_address;
                writes_left  = w.write_count;
                reads_wanted = w.read_count;
                reads_done   = '0;
                if (writes_left != 0) begin
                    r.bus_command = CMD_ADDR;
                    r.bus_byte    = {target, ~READ_BIT};
                end else if (reads_wanted != 0) begin
                    r.bus_command = CMD_ADDR;
                    r.bus_byte    = {target, READ_BIT};
                end
            end
            OP_EVENT: begin
                if (w.bus_error || w.arbitration_lost) begin
                    last_res            = w.bus_error ? RES_BUS_ERROR : RES_ARB_LOST;
                    r.clear_error_flags = 1'b1;
                    busy                = 1'b0;
                end else if (w.write_done_flag) begin
                    idle_secs = '0;
                    if (w.slave_nacked) begin
                        r.bus_command = CMD_STOP;
                        last_res      = RES_NACK;
                        busy          = 1'b0;
                    end else if (writes_left != 0) begin
                        writes_left   = writes_left - 8'd1;
                        r.bus_command = CMD_DATA;
                        r.bus_byte    = w.next_write_byte;
                    end else if (reads_done < reads_wanted) begin
                        r.bus_command = CMD_ADDR;
                        r.bus_byte    = {target, READ_BIT};
                    end else begin
                        r.bus_command = CMD_STOP;
                        last_res      = RES_OK;
                        busy          = 1'b0;
                    end
                end else if (w.read_done_flag) begin
                    r.read_valid = 1'b1;
                    r.read_data  = w.received_byte;
                    if (reads_done != COUNT_MAX)
                        reads_done = reads_done + 8'd1;
                    if (reads_done < reads_wanted) begin
                        r.bus_command = CMD_ACK_RECV;
                    end else begin
                        r.bus_command = CMD_NACK_STOP;
                        last_res      = RES_OK;
                        busy          = 1'b0;
                    end
                end else begin
                    last_res = RES_FAIL;
                    busy     = 1'b0;
                end
            end
            OP_TICK: begin
                if (idle_secs != COUNT_MAX)
                    idle_secs = idle_secs + 8'd1;
                if (idle_secs > timeout_secs) begin
                    idle_secs   = '0;
                    last_res    = RES_UNKNOWN;
                    busy        = 1'b0;
                    r.restarted = 1'b1;
                end
            end
            default: ;
        endcase
        r.busy_res    = busy;
        r.result_code = last_res;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            busy         = 1'b0;
            last_res     = RES_UNKNOWN;
            target       = '0;
            writes_left  = '0;
            reads_wanted = '0;
            reads_done   = '0;
            idle_secs    = '0;
            timeout_secs = TIMEOUT_RESET;
            awaited_results.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == {REG_IDLE_TIMEOUT, 2'b00}) begin
                if (i_pwrite)
                    timeout_secs = i_pwdata[7:0];
                else if (i_prdata !== {24'd0, timeout_secs})
                    report_mismatch("idle timeout readback", {24'd0, timeout_secs}, i_prdata);
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result word", 32'd0, 32'(i_out_word));
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("bus_command", 8'(want.bus_command),
                                  8'(i_out_word.bus_command));
                    compare_field("bus_byte", want.bus_byte, i_out_word.bus_byte);
                    compare_field("read_valid", 8'(want.read_valid),
                                  8'(i_out_word.read_valid));
                    compare_field("read_data", want.read_data, i_out_word.read_data);
                    compare_field("clear_error_flags", 8'(want.clear_error_flags),
                                  8'(i_out_word.clear_error_flags));
                    compare_field("busy_res", 8'(want.busy_res), 8'(i_out_word.busy_res));
                    compare_field("result_code", 8'(want.result_code),
                                  8'(i_out_word.result_code));
                    compare_field("restarted", 8'(want.restarted),
                                  8'(i_out_word.restarted));
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(next_bus_result(i_in_word));
        end
        o_pending <= awaited_results.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the I2C transaction sequencer
// Drives directed and random start, bus event and tick words through the
// valid/ready input channel under several idle timeouts and back-pressure
// patterns; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import i2cmts_pkg::*;

    // the unused fourth operation code; the block must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // event flag sets, ordered {bus_error, arbitration_lost, write_done,
    // read_done, slave_nacked}
    localparam logic [4:0] F_NONE  = 5'b00000;
    localparam logic [4:0] F_BERR  = 5'b10000;
    localparam logic [4:0] F_ARB   = 5'b01000;
    localparam logic [4:0] F_WDONE = 5'b00100;
    localparam logic [4:0] F_RDONE = 5'b00010;
    localparam logic [4:0] F_NACK  = 5'b00001;

    localparam int NUM_PHASES  = 8;
    localparam int PHASE_WORDS = 140;
    localparam int DRAIN_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_word    in_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_word   out_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int pending;
    int fail_count;
    int words_sent = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;

    // timeout per phase: extremes and a mix, with the reset value last
    logic [7:0] phase_timeout [NUM_PHASES];

    i2c_master_transaction_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    i2cmts_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #2 clk = ~clk;

    // hard stop in case a handshake never completes
    initial begin
        #2ms;
        $display("tb_top failed");
        $finish;
    end

    // result side: stall at the rate set by the current phase
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------
    function automatic t_in_word make_word(input logic [1:0] op, input logic [6:0] addr,
                                           input logic [7:0] wcount, input logic [7:0] rcount,
                                           input logic [7:0] wbyte, input logic [4:0] flags,
                                           input logic [7:0] rbyte);
        t_in_word w;
        w.operation       = op;
        w.slave_address   = addr;
        w.write_count     = wcount;
        w.read_count      = rcount;
        w.next_write_byte = wbyte;
        {w.bus_error, w.arbitration_lost, w.write_done_flag, w.read_done_flag,
         w.slave_nacked}  = flags;
        w.received_byte   = rbyte;
        return w;
    endfunction

    // every field but the operation random, so every such bit sees both values
    function automatic t_in_word random_word(input logic [1:0] op);
        logic [63:0] raw;
        t_in_word    w;
        raw         = {$urandom, $urandom};
        w           = raw[$bits(t_in_word)-1:0];
        w.operation = op;
        return w;
    endfunction

    function automatic t_in_word random_event(input logic [4:0] flags);
        t_in_word w;
        w = random_word(OP_EVENT);
        {w.bus_error, w.arbitration_lost, w.write_done_flag, w.read_done_flag,
         w.slave_nacked} = flags;
        return w;
    endfunction

    // mostly short transfers, now and then any count up to the maximum
    function automatic logic [7:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 8'($urandom_range(2));
        else if (r < 85)
            return 8'($urandom_range(6, 3));
        return 8'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // Present one word and hold it until taken. Valid stays high across
    // back-to-back words; it drops only for a sender idle cycle.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // the checker compares the returned value with its own copy
    task automatic read_reg(input logic [2:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // Start a transfer and follow it with the engine events a real bus
    // would report: write-done for the address and each data byte, then
    // read-done for each byte. Now and then slip in a tick or break the
    // transfer with an error, a nack or an empty event.
    task automatic run_transfer(input int max_events);
        t_in_word w;
        int       n_wr;
        int       n_total;
        int       r;
        w = random_word(OP_START);
        w.write_count = pick_count();
        w.read_count  = pick_count();
        send_word(w);
        n_wr    = (w.write_count != 0) ? int'(w.write_count) + 1 : 0;
        n_total = n_wr + int'(w.read_count);
        // sometimes read past the wanted count
        if ($urandom_range(9) == 0)
            n_total += $urandom_range(2, 1);
        if (n_total > max_events)
            n_total = max_events;
        for (int i = 0; i < n_total; i++) begin
            r = $urandom_range(99);
            if (r < 5)
                send_word(random_word(OP_TICK));
            if (r >= 5 && r < 9) begin
                case ($urandom_range(3))
                    0:       send_word(random_event(F_BERR | 5'($urandom_range(15))));
                    1:       send_word(random_event(F_ARB | 5'($urandom_range(7))));
                    2:       send_word(random_event(F_WDONE | F_NACK | 5'($urandom_range(1) << 1)));
                    default: send_word(random_event(F_NONE | 5'($urandom_range(1))));
                endcase
                return;
            end
            if (i < n_wr)
                send_word(random_event(F_WDONE | 5'($urandom_range(1) << 1)));
            else
                send_word(random_event(F_RDONE | 5'($urandom_range(1))));
        end
    endtask

    task automatic run_directed();
        // event with no flag while idle: fail
        send_word(make_word(OP_EVENT, 7'h7F, 8'hFF, 8'hFF, 8'hFF, F_NONE, 8'hFF));
        // empty transfer, then a start that replaces it
        send_word(make_word(OP_START, 7'h7F, 8'd0, 8'd0, 8'h00, F_NONE, 8'h00));
        send_word(make_word(OP_START, 7'h00, 8'd2, 8'd1, 8'h00, F_NONE, 8'h00));
        // two data bytes, repeated start, one read, one read beyond the count
        send_word(make_word(OP_EVENT, 7'h00, 8'd0, 8'd0, 8'hFF, F_WDONE | F_RDONE, 8'h00));
        send_word(make_word(OP_EVENT, 7'h00, 8'd0, 8'd0, 8'h00, F_WDONE, 8'hFF));
        send_word(make_word(OP_EVENT, 7'h00, 8'd0, 8'd0, 8'h00, F_WDONE, 8'h00));
        send_word(make_word(OP_EVENT, 7'h00, 8'd0, 8'd0, 8'h00, F_RDONE, 8'hA5));
        send_word(make_word(OP_EVENT, 7'h00, 8'd0, 8'd0, 8'h00, F_RDONE, 8'h5A));
        // read-only transfer, one ack, then both error flags: bus error wins
        send_word(make_word(OP_START, 7'h55, 8'd0, 8'd3, 8'h00, F_NONE, 8'h00));
        send_word(make_word(OP_EVENT, 7'h00, 8'd0, 8'd0, 8'h00, F_RDONE, 8'h3C));
        send_word(make_word(OP_EVENT, 7'h00, 8'd0, 8'd0, 8'h00,
                            F_BERR | F_ARB | F_WDONE, 8'h00));
        // write-only transfer ending in stop
        send_word(make_word(OP_START, 7'h2A, 8'd1, 8'd0, 8'h00, F_NONE, 8'h00));
        send_word(make_word(OP_EVENT, 7'h00, 8'd0, 8'd0, 8'hC3, F_WDONE, 8'h00));
        send_word(make_word(OP_EVENT, 7'h00, 8'd0, 8'd0, 8'h00, F_WDONE, 8'h00));
        // slave nack on the address
        send_word(make_word(OP_START, 7'h01, 8'd1, 8'd2, 8'h00, F_NONE, 8'h00));
        send_word(make_word(OP_EVENT, 7'h00, 8'd0, 8'd0, 8'h00, F_WDONE | F_NACK, 8'h00));
        // largest counts, then arbitration loss and bus error on their own
        send_word(make_word(OP_START, 7'h7F, 8'hFF, 8'hFF, 8'h00, F_NONE, 8'h00));
        send_word(make_word(OP_EVENT, 7'h00, 8'd0, 8'd0, 8'h00, F_ARB, 8'h00));
        send_word(make_word(OP_EVENT, 7'h00, 8'd0, 8'd0, 8'h00, F_BERR, 8'h00));
        // unused operation: nothing happens
        send_word(make_word(OP_UNUSED, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 5'b11111, 8'hFF));
        // six ticks since the last write-done: the sixth trips a timeout of five
        repeat (6)
            send_word(make_word(OP_TICK, 7'h00, 8'd0, 8'd0, 8'h00, F_NONE, 8'h00));
    endtask

    task automatic run_phase(input int phase);
        int phase_end;
        int r;
        phase_end = words_sent + PHASE_WORDS;
        // a timeout of 255 never fires: hold ticks past counter saturation
        if (phase_timeout[phase] == COUNT_MAX)
            repeat (300) send_word(random_word(OP_TICK));
        // long read run: drive reads_done into saturation
        if (phase == 2) begin
            send_word(make_word(OP_START, 7'($urandom_range(127)), 8'd0, COUNT_MAX,
                                8'h00, F_NONE, 8'h00));
            repeat (258) send_word(random_event(F_RDONE | 5'($urandom_range(1))));
        end
        while (words_sent < phase_end) begin
            r = $urandom_range(99);
            if (r < 80)
                run_transfer(24);
            else if (r < 92)
                send_word(random_word(2'($urandom_range(3))));
            else
                repeat ($urandom_range(8, 1)) send_word(random_word(OP_TICK));
        end
    endtask

    initial begin
        int guard;
        phase_timeout[0] = 8'd255;
        phase_timeout[1] = 8'd0;
        phase_timeout[2] = 8'd1;
        phase_timeout[3] = 8'd3;
        phase_timeout[4] = 8'($urandom_range(255));
        phase_timeout[5] = 8'd254;
        phase_timeout[6] = 8'($urandom_range(2, 8));
        phase_timeout[7] = TIMEOUT_RESET;

        // hold reset low from the start, then release it for good
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the timeout, then the directed words with no idling
        read_reg({REG_IDLE_TIMEOUT, 2'b00});
        run_directed();
        drain();

        // idling modes rotate: none, sender idle, receiver stall, both light
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg({REG_IDLE_TIMEOUT, 2'b00}, {24'd0, phase_timeout[p]});
            read_reg({REG_IDLE_TIMEOUT, 2'b00});
            case (p % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 86;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 86;
                end
                default: begin
                    sender_idle_pct = 6;
                    recv_stall_pct  = 6;
                end
            endcase
            run_phase(p);
            drain();
        end

        // final drain with a limit, then wait for any stray result
        in_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        if (pending != 0) begin
            $display("tb_top failed");
        end else begin
            repeat (8) @(posedge clk);
            if (fail_count == 0)
                $display("tb_top passed");
            else
                $display("tb_top failed");
        end
        $finish;
    end

endmodule
